### design/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and microprogram for the page protection map
// Holds the action codes, the datapath operation codes, the jump conditions,
// the control word layout and the read-only microprogram.
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_pkg;

    // Width of one table entry: read, write, exec and locked bits.
    localparam int ENTRY_W = 4;
    localparam logic [ENTRY_W-1:0] ENTRY_FREE   = 4'b0000;
    localparam logic [ENTRY_W-1:0] ENTRY_LOCKED = 4'b1000;

    // The user region spans 4 GiB above the base address.
    localparam logic [64:0] REGION_BYTES = 65'h1_0000_0000;

    // Request codes carried by the action field.
    typedef enum logic [1:0] {
        ACT_CHECK    = 2'd0,
        ACT_UPDATE   = 2'd1,
        ACT_LOCK     = 2'd2,
        ACT_RESERVED = 2'd3
    } action_t;

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        DP_NONE      = 4'd0,
        DP_OFFSET    = 4'd1,
        DP_SPAN      = 4'd2,
        DP_FIT       = 4'd3,
        DP_WALK_TEST = 4'd4,
        DP_REWIND    = 4'd5,
        DP_WRITE     = 4'd6,
        DP_ALL       = 4'd7,
        DP_CLEAR     = 4'd8,
        DP_WALK_LOCK = 4'd9,
        DP_PASS      = 4'd10,
        DP_FAIL      = 4'd11
    } dp_op_t;

    // Jump conditions tested by the sequencer.
    typedef enum logic [3:0] {
        C_NEVER      = 4'd0,
        C_ALWAYS     = 4'd1,
        C_ACCEPT     = 4'd2,
        C_DISPATCH   = 4'd3,
        C_CNT_MORE   = 4'd4,
        C_WALK_BUSY  = 4'd5,
        C_FAIL       = 4'd6,
        C_SKIP_WRITE = 4'd7,
        C_OUT_FREE   = 4'd8
    } cond_t;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    // Microprogram addresses.
    localparam upc_t U_INIT      = 4'd0;
    localparam upc_t U_CLEAR     = 4'd1;
    localparam upc_t U_IDLE      = 4'd2;
    localparam upc_t U_DISPATCH  = 4'd3;
    localparam upc_t U_SPAN      = 4'd4;
    localparam upc_t U_FIT       = 4'd5;
    localparam upc_t U_WALK      = 4'd6;
    localparam upc_t U_BRANCH    = 4'd7;
    localparam upc_t U_REWIND    = 4'd8;
    localparam upc_t U_WRITE     = 4'd9;
    localparam upc_t U_REPORT    = 4'd10;
    localparam upc_t U_LOCK      = 4'd11;
    localparam upc_t U_LOCK_WALK = 4'd12;
    localparam upc_t U_LOCK_DONE = 4'd13;
    localparam upc_t U_BAD       = 4'd14;

    // One control word. A taken condition loads target; otherwise the
    // sequencer either holds the step or moves to the next one.
    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        upc_t   target;
        logic   hold;
        logic   ready;
        logic   emit;
    } uword_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic       cnt_more;
        logic       cnt_nz;
        logic       fail;
        logic [1:0] action;
        logic       out_free;
    } dp_flags_t;

    // Read-only microprogram.
    function automatic uword_t ucode(input upc_t addr);
        uword_t w;
        w = '{op: DP_NONE, cond: C_ALWAYS, target: U_IDLE,
              hold: 1'b0, ready: 1'b0, emit: 1'b0};
        case (addr)
            U_INIT:      w = '{DP_ALL,       C_NEVER,      U_INIT,      1'b0, 1'b0, 1'b0};
            U_CLEAR:     w = '{DP_CLEAR,     C_CNT_MORE,   U_CLEAR,     1'b0, 1'b0, 1'b0};
            U_IDLE:      w = '{DP_NONE,      C_ACCEPT,     U_DISPATCH,  1'b1, 1'b1, 1'b0};
            U_DISPATCH:  w = '{DP_OFFSET,    C_DISPATCH,   U_SPAN,      1'b0, 1'b0, 1'b0};
            U_SPAN:      w = '{DP_SPAN,      C_NEVER,      U_SPAN,      1'b0, 1'b0, 1'b0};
            U_FIT:       w = '{DP_FIT,       C_FAIL,       U_REPORT,    1'b0, 1'b0, 1'b0};
            U_WALK:      w = '{DP_WALK_TEST, C_WALK_BUSY,  U_WALK,      1'b0, 1'b0, 1'b0};
            U_BRANCH:    w = '{DP_NONE,      C_SKIP_WRITE, U_REPORT,    1'b0, 1'b0, 1'b0};
            U_REWIND:    w = '{DP_REWIND,    C_NEVER,      U_REWIND,    1'b0, 1'b0, 1'b0};
            U_WRITE:     w = '{DP_WRITE,     C_CNT_MORE,   U_WRITE,     1'b0, 1'b0, 1'b0};
            U_REPORT:    w = '{DP_NONE,      C_OUT_FREE,   U_IDLE,      1'b1, 1'b0, 1'b1};
            U_LOCK:      w = '{DP_ALL,       C_NEVER,      U_LOCK,      1'b0, 1'b0, 1'b0};
            U_LOCK_WALK: w = '{DP_WALK_LOCK, C_WALK_BUSY,  U_LOCK_WALK, 1'b0, 1'b0, 1'b0};
            U_LOCK_DONE: w = '{DP_PASS,      C_ALWAYS,     U_REPORT,    1'b0, 1'b0, 1'b0};
            U_BAD:       w = '{DP_FAIL,      C_ALWAYS,     U_REPORT,    1'b0, 1'b0, 1'b0};
            default:     w = '{DP_NONE,      C_ALWAYS,     U_IDLE,      1'b0, 1'b0, 1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### design/ppm_ram.sv
// ----------------------------------------------------------------------------
// ppm_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/ppm_useq.sv
// ----------------------------------------------------------------------------
// ppm_useq: microcode sequencer
// Step counter, microprogram ROM lookup and conditional jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_useq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ppm_pkg::dp_flags_t flags,
    output ppm_pkg::uword_t   uw
);
    import ppm_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    upc_t jump_target;
    logic taken;

    // Current control word.
    assign uw = ucode(upc_reg);

    // Evaluate the jump condition of this step.
    always_comb
    begin
        taken       = 1'b0;
        jump_target = uw.target;
        case (uw.cond)
            C_NEVER:      taken = 1'b0;
            C_ALWAYS:     taken = 1'b1;
            C_ACCEPT:     taken = accept;
            C_CNT_MORE:   taken = flags.cnt_more;
            C_WALK_BUSY:  taken = flags.cnt_nz;
            C_FAIL:       taken = flags.fail;
            C_SKIP_WRITE: taken = flags.fail || (flags.action != ACT_UPDATE);
            C_OUT_FREE:   taken = flags.out_free;
            C_DISPATCH:
            begin
                taken = 1'b1;
                case (flags.action)
                    ACT_CHECK, ACT_UPDATE: jump_target = U_SPAN;
                    ACT_LOCK:              jump_target = U_LOCK;
                    default:               jump_target = U_BAD;
                endcase
            end
            default:      taken = 1'b0;
        endcase
    end

    // Next step: taken jump, hold, or fall through.
    always_comb
    begin
        if (taken)
        begin
            upc_next = jump_target;
        end
        else if (uw.hold)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_reg + upc_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_INIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

### design/ppm_dpath.sv
// ----------------------------------------------------------------------------
// ppm_dpath: request datapath of the page protection map
// Holds the request, the range arithmetic, the page walker that drives the
// table RAM, the pass/fail flag and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_dpath #(
    parameter int MAP_ENTRIES = 65536,
    parameter int PAGE_SHIFT  = 16,
    parameter int AW          = 16,
    parameter int CW          = 19
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ppm_pkg::uword_t              uw,
    input  logic                         accept,
    input  logic [1:0]                   action,
    input  logic [63:0]                  address,
    input  logic [31:0]                  byte_size,
    input  logic [2:0]                   prot_mask,
    input  logic                         cfg_write,
    input  logic [63:0]                  cfg_data,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic                         status,
    output ppm_pkg::dp_flags_t           flags,
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output logic [ppm_pkg::ENTRY_W-1:0]  ram_wdata,
    output logic                         ram_re,
    output logic [AW-1:0]                ram_raddr,
    input  logic [ppm_pkg::ENTRY_W-1:0]  ram_rdata
);
    import ppm_pkg::*;

    localparam logic [32:0] PAGE_ROUND = 33'((64'd1 << PAGE_SHIFT) - 64'd1);

    // Request and configuration registers.
    logic [63:0] base_reg;
    logic [1:0]  action_reg;
    logic [63:0] addr_reg;
    logic [31:0] size_reg;
    logic [2:0]  mask_reg;

    // Walker state.
    logic [63:0]   off_reg,   off_next;
    logic [CW-1:0] pages_reg, pages_next;
    logic [CW-1:0] first_reg, first_next;
    logic [AW-1:0] idx_reg,   idx_next;
    logic [AW-1:0] lag_reg,   lag_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic          pend_reg,  pend_next;
    logic          flag_reg,  flag_next;
    logic          out_valid_reg, out_valid_next;
    logic          status_reg,    status_next;

    // Arithmetic terms.
    logic [64:0]   diff;
    logic [32:0]   pages_sum;
    logic [64:0]   span_sum;
    logic [CW-1:0] fit_sum;
    logic          span_bad;
    logic          fit_bad;
    logic [2:0]    test_mask;
    logic          test_bad;
    logic          cnt_nz;
    logic          out_free;

    assign cnt_nz   = (cnt_reg != '0);
    assign out_free = !(out_valid_reg && out_stall);

    // Range arithmetic: offset in region, page count, end of range, table fit.
    assign diff      = {1'b0, addr_reg} - {1'b0, base_reg};
    assign pages_sum = {1'b0, size_reg} + PAGE_ROUND;
    assign span_sum  = {1'b0, off_reg} + 65'(size_reg);
    assign span_bad  = (span_sum > REGION_BYTES);
    assign fit_sum   = first_reg + pages_reg;
    assign fit_bad   = (fit_sum > CW'(MAP_ENTRIES));

    // Entry test: lock bit for an update or a zero mask, else the mask bits.
    assign test_mask = (action_reg == ACT_UPDATE) ? 3'b000 : mask_reg;
    always_comb
    begin
        if (test_mask == 3'b000)
        begin
            test_bad = pend_reg && ram_rdata[ENTRY_W-1];
        end
        else
        begin
            test_bad = pend_reg && ((ram_rdata[2:0] & test_mask) == 3'b000);
        end
    end

    // Datapath operation of the current step.
    always_comb
    begin
        off_next   = off_reg;
        pages_next = pages_reg;
        first_next = first_reg;
        idx_next   = idx_reg;
        lag_next   = lag_reg;
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        flag_next  = flag_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = ENTRY_FREE;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg;
        case (uw.op)
            DP_OFFSET:
            begin
                off_next   = diff[63:0];
                flag_next  = diff[64];
                pages_next = CW'(pages_sum >> PAGE_SHIFT);
            end
            DP_SPAN:
            begin
                flag_next  = flag_reg | span_bad;
                first_next = CW'(off_reg[32:PAGE_SHIFT]);
            end
            DP_FIT:
            begin
                flag_next = flag_reg | fit_bad;
                idx_next  = first_reg[AW-1:0];
                cnt_next  = pages_reg;
            end
            DP_REWIND:
            begin
                idx_next = first_reg[AW-1:0];
                cnt_next = pages_reg;
            end
            DP_ALL:
            begin
                idx_next = '0;
                cnt_next = CW'(MAP_ENTRIES);
            end
            DP_WALK_TEST:
            begin
                ram_re    = cnt_nz;
                pend_next = cnt_nz;
                lag_next  = idx_reg;
                flag_next = flag_reg | test_bad;
                if (cnt_nz)
                begin
                    idx_next = idx_reg + AW'(1);
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            DP_WALK_LOCK:
            begin
                ram_re    = cnt_nz;
                pend_next = cnt_nz;
                lag_next  = idx_reg;
                ram_we    = pend_reg && (ram_rdata == ENTRY_FREE);
                ram_waddr = lag_reg;
                ram_wdata = ENTRY_LOCKED;
                if (cnt_nz)
                begin
                    idx_next = idx_reg + AW'(1);
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            DP_WRITE:
            begin
                ram_we    = cnt_nz;
                ram_wdata = {1'b0, mask_reg};
                if (cnt_nz)
                begin
                    idx_next = idx_reg + AW'(1);
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            DP_CLEAR:
            begin
                ram_we    = cnt_nz;
                ram_wdata = ENTRY_FREE;
                if (cnt_nz)
                begin
                    idx_next = idx_reg + AW'(1);
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            DP_PASS:  flag_next = 1'b0;
            DP_FAIL:  flag_next = 1'b1;
            DP_NONE:  flag_next = flag_reg;
            default:  flag_next = flag_reg;
        endcase
    end

    // Output register: loads on a report step once the previous beat is gone.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        if (uw.emit && out_free)
        begin
            out_valid_next = 1'b1;
            status_next    = flag_reg;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers and the region base.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                base_reg <= cfg_data;
            end
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            addr_reg   <= address;
            size_reg   <= byte_size;
            mask_reg   <= prot_mask;
        end
        off_reg    <= off_next;
        pages_reg  <= pages_next;
        first_reg  <= first_next;
        idx_reg    <= idx_next;
        lag_reg    <= lag_next;
        status_reg <= status_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign flags.cnt_more = (cnt_reg > CW'(1));
    assign flags.cnt_nz   = cnt_nz;
    assign flags.fail     = flag_reg;
    assign flags.action   = action_reg;
    assign flags.out_free = out_free;

endmodule

`default_nettype wire

### design/page_protection_map_core.sv
// ----------------------------------------------------------------------------
// page_protection_map_core: per-page protection table over a 4 GiB region
// Checks and updates protection masks over page ranges and locks free pages.
// A microcode sequencer steps a small datapath that walks the table RAM.
//
//   Channel   Signals                                        Handshake
//   input     action, address, byte_size, prot_mask          in_valid / in_stall
//   output    status                                         out_valid / out_stall
//   config    cfg_data (region_base)                         cfg_valid / cfg_ready
//
// Run time is set by the table RAM walk of one entry per cycle: a check walks
// its pages once, an update twice (test, then write), a lock the whole table.
// After reset the sequencer clears the whole table with in_stall high;
// configuration writes are taken during that pass.
// One request is in work at a time; a finished status beat waits in the
// output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module page_protection_map_core #(
    parameter int MAP_ENTRIES = 65536,
    parameter int PAGE_SHIFT  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [63:0] address,
    input  logic [31:0] byte_size,
    input  logic [2:0]  prot_mask,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);
    import ppm_pkg::*;

    localparam int AW        = $clog2(MAP_ENTRIES);
    localparam int SPAN_BITS = 33 - PAGE_SHIFT;
    localparam int CW        = ((AW + 1 > SPAN_BITS) ? AW + 1 : SPAN_BITS) + 1;

    uword_t              uw;
    dp_flags_t           flags;
    logic                accept;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    // Requests are taken only in the idle step of the microprogram.
    assign in_stall  = !uw.ready;
    assign accept    = in_valid && uw.ready;
    assign cfg_ready = 1'b1;

    ppm_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .flags  (flags),
        .uw     (uw)
    );

    ppm_dpath #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .PAGE_SHIFT  (PAGE_SHIFT),
        .AW          (AW),
        .CW          (CW)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .uw        (uw),
        .accept    (accept),
        .action    (action),
        .address   (address),
        .byte_size (byte_size),
        .prot_mask (prot_mask),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .status    (status),
        .flags     (flags),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Protection table, one entry per page.
    ppm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAP_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### design/ppm_checker.sv
// ----------------------------------------------------------------------------
// ppm_checker: port-level assertions for page_protection_map_core
// Tracks requests in flight from the handshakes and checks ordering rules.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic status
);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    // Requests taken whose status beat has not been delivered yet.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_beat && !out_beat)
        begin
            inflight_next = inflight_reg + 2'd1;
        end
        else if (out_beat && !in_beat)
        begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A request is never followed by another in the next cycle.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> in_stall)
        else $error("request taken in the cycle after a request");

    // No status beat without a request behind it.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> (inflight_reg != 2'd0))
        else $error("status beat without an outstanding request");

    // At most one finished beat waits while a new request is taken.
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> (inflight_reg == 2'd0 || inflight_reg == 2'd1))
        else $error("request taken with two requests outstanding");

    // A stalled status beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)))
        else $error("stalled status beat changed");

endmodule

bind page_protection_map_core ppm_checker u_checker (.*);

`default_nettype wire

### sim/page_protection_map_core_tb.sv
// ----------------------------------------------------------------------------
// page_protection_map_core_tb: self-checking bench for the page protection map
// A table of directed requests is followed by random phases, each with its own
// region base. Check, update, lock and reserved requests are mixed. A local
// copy of the protection table predicts the status of every accepted request.
// Each status beat is compared in order. Both channels idle and stall at
// random throughout the run.
// ----------------------------------------------------------------------------
module page_protection_map_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppm_pkg::*;

    localparam int MAP_ENTRIES = 65536;
    localparam int PAGE_SHIFT  = 16;

    localparam logic [63:0] PAGE_BYTES   = 64'd1 << PAGE_SHIFT;
    localparam logic [63:0] REGION_SPAN  = 64'h1_0000_0000;
    localparam logic [63:0] TABLE_PAGES  = 64'(MAP_ENTRIES);
    localparam int          WINDOW_PAGES = 4160;

    // Status codes on the result channel.
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    // Row kinds and expectation sources of the directed table.
    localparam logic ROW_REQ = 1'b0;
    localparam logic ROW_CFG = 1'b1;
    localparam logic PREDICT = 1'b0;
    localparam logic TYPED   = 1'b1;

    // The run limit leaves room for the clearing pass, a few table-wide walks
    // and about 1600 short requests with idling.
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int TAIL_CYCLES = 64;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 310;

    localparam logic [63:0] DIR_BASE = 64'h0000_0001_0000_0000;

    typedef struct packed {
        logic        is_cfg;
        action_t     act;
        logic [63:0] addr;
        logic [31:0] size;
        logic [2:0]  mask;
        logic        typed;
        logic        want;
    } stim_row_t;

    typedef struct {
        logic        status;
        int unsigned seq;
    } status_exp_t;

    localparam int DIR_ROWS = 29;
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_CFG, ACT_CHECK,    DIR_BASE,                    32'd0,          3'd0, PREDICT, ST_OK},
        // Address one byte below the region.
        '{ROW_REQ, ACT_CHECK,    DIR_BASE - 64'd1,            32'd0,          3'd0, TYPED, ST_REFUSED},
        // Zero length at the region start.
        '{ROW_REQ, ACT_CHECK,    DIR_BASE,                    32'd0,          3'd0, TYPED, ST_OK},
        // A free page refuses any nonzero mask.
        '{ROW_REQ, ACT_CHECK,    DIR_BASE,                    32'h0001_0000,  3'd1, TYPED, ST_REFUSED},
        // Largest length over a freshly cleared table.
        '{ROW_REQ, ACT_CHECK,    DIR_BASE,                    32'hFFFF_FFFF,  3'd0, TYPED, ST_OK},
        // Largest length two bytes in runs past the region end.
        '{ROW_REQ, ACT_CHECK,    DIR_BASE + 64'd2,            32'hFFFF_FFFF,  3'd0, TYPED, ST_REFUSED},
        '{ROW_REQ, ACT_CHECK,    DIR_BASE + 64'hFFFF_FFFF,    32'd1,          3'd0, PREDICT, ST_OK},
        '{ROW_REQ, ACT_CHECK,    DIR_BASE + REGION_SPAN,      32'd0,          3'd0, PREDICT, ST_OK},
        '{ROW_REQ, ACT_CHECK,    64'hFFFF_FFFF_FFFF_FFFF,     32'd1,          3'd7, TYPED, ST_REFUSED},
        // Fill the first 4096 pages with one mask per 1024-page block.
        '{ROW_REQ, ACT_UPDATE,   DIR_BASE,                    32'h0400_0000,  3'd7, TYPED, ST_OK},
        '{ROW_REQ, ACT_UPDATE,   DIR_BASE + 64'h0400_0000,    32'h0400_0000,  3'd1, PREDICT, ST_OK},
        '{ROW_REQ, ACT_UPDATE,   DIR_BASE + 64'h0800_0000,    32'h0400_0000,  3'd2, PREDICT, ST_OK},
        '{ROW_REQ, ACT_UPDATE,   DIR_BASE + 64'h0C00_0000,    32'h0400_0000,  3'd4, PREDICT, ST_OK},
        '{ROW_REQ, ACT_CHECK,    DIR_BASE + 64'h0400_8000,    32'h0002_0000,  3'd6, PREDICT, ST_OK},
        '{ROW_REQ, ACT_CHECK,    DIR_BASE + 64'h0400_0000,    32'h0003_0001,  3'd3, PREDICT, ST_OK},
        // Page count follows the length alone, not the offset in the page.
        '{ROW_REQ, ACT_UPDATE,   DIR_BASE + 64'd16,           32'h0001_0001,  3'd0, PREDICT, ST_OK},
        '{ROW_REQ, ACT_RESERVED, DIR_BASE,                    32'd1,          3'd7, TYPED, ST_REFUSED},
        // Lock with every ignored field at its top value.
        '{ROW_REQ, ACT_LOCK,     64'hFFFF_FFFF_FFFF_FFFF,     32'hFFFF_FFFF,  3'd7, TYPED, ST_OK},
        '{ROW_REQ, ACT_CHECK,    DIR_BASE,                    32'h0001_0000,  3'd0, PREDICT, ST_OK},
        '{ROW_REQ, ACT_UPDATE,   DIR_BASE + 64'h0000_FFFF,    32'd1,          3'd7, PREDICT, ST_OK},
        '{ROW_REQ, ACT_UPDATE,   DIR_BASE + 64'h0002_0000,    32'h0001_0000,  3'd0, PREDICT, ST_OK},
        '{ROW_REQ, ACT_CHECK,    DIR_BASE + 64'h0002_0000,    32'h0001_0000,  3'd7, PREDICT, ST_OK},
        '{ROW_REQ, ACT_CHECK,    DIR_BASE + 64'h0002_0000,    32'h0001_0000,  3'd0, PREDICT, ST_OK},
        '{ROW_CFG, ACT_CHECK,    64'hFFFF_FFFF_FFFF_FFFF,     32'd0,          3'd0, PREDICT, ST_OK},
        '{ROW_REQ, ACT_CHECK,    64'hFFFF_FFFF_FFFF_FFFF,     32'd0,          3'd0, TYPED, ST_OK},
        '{ROW_REQ, ACT_CHECK,    64'hFFFF_FFFF_FFFF_FFFE,     32'd0,          3'd0, TYPED, ST_REFUSED},
        '{ROW_CFG, ACT_CHECK,    64'd0,                       32'd0,          3'd0, PREDICT, ST_OK},
        '{ROW_REQ, ACT_CHECK,    64'd0,                       32'h0010_0000,  3'd7, PREDICT, ST_OK},
        '{ROW_REQ, ACT_UPDATE,   64'h0000_0000_FFFF_0000,     32'h0001_0000,  3'd5, PREDICT, ST_OK}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [63:0] address;
    logic [31:0] byte_size;
    logic [2:0]  prot_mask;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;

    // Expectation source of the beat on the input channel.
    logic        row_typed;
    logic        row_want;

    // Local copy of the block state.
    logic [3:0]  page_prot [MAP_ENTRIES];
    logic [63:0] user_base;

    status_exp_t pending_status [$];
    int unsigned accepted_items = 0;
    int unsigned errors         = 0;
    int unsigned cycle_count    = 0;
    int          burst_left     = 0;
    int          stall_left     = 0;

    page_protection_map_core #(
        .MAP_ENTRIES(MAP_ENTRIES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .address  (address),
        .byte_size(byte_size),
        .prot_mask(prot_mask),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // Applies one request to the local table and returns its status.
    function automatic logic run_page_request(input action_t act, input logic [63:0] addr,
                                              input logic [31:0] size, input logic [2:0] mask);
        logic [63:0] off;
        logic [63:0] pages;
        logic [63:0] first;
        logic [2:0]  test_mask;
        logic        fits;
        logic        ok;
        logic [3:0]  entry;
        int          i;
        fits  = 1'b0;
        ok    = 1'b1;
        pages = '0;
        first = '0;
        if (addr >= user_base)
        begin
            off   = addr - user_base;
            pages = ({32'd0, size} + PAGE_BYTES - 64'd1) >> PAGE_SHIFT;
            first = off >> PAGE_SHIFT;
            fits  = (off <= REGION_SPAN - {32'd0, size}) && (first <= TABLE_PAGES)
                    && (pages <= TABLE_PAGES - first);
        end
        case (act)
            ACT_CHECK, ACT_UPDATE:
            begin
                if (!fits)
                    return ST_REFUSED;
                // An update first asks whether the range is free of locks.
                test_mask = (act == ACT_CHECK) ? mask : 3'd0;
                for (i = 0; i < pages && ok; i++)
                begin
                    entry = page_prot[first + i];
                    if (test_mask == 3'd0)
                        ok = ((entry & ENTRY_LOCKED) == ENTRY_FREE);
                    else
                        ok = ((entry[2:0] & test_mask) != 3'd0);
                end
                if (!ok)
                    return ST_REFUSED;
                if (act == ACT_UPDATE)
                    for (i = 0; i < pages; i++)
                        page_prot[first + i] = {1'b0, mask};
                return ST_OK;
            end
            ACT_LOCK:
            begin
                for (i = 0; i < MAP_ENTRIES; i++)
                    if (page_prot[i] == ENTRY_FREE)
                        page_prot[i] = ENTRY_LOCKED;
                return ST_OK;
            end
            default:
                return ST_REFUSED;
        endcase
    endfunction

    // Presents one request beat and holds it until it is taken.
    task automatic send_item(input action_t act, input logic [63:0] addr,
                             input logic [31:0] size, input logic [2:0] mask,
                             input logic typed, input logic want);
        action    <= act;
        address   <= addr;
        byte_size <= size;
        prot_mask <= mask;
        row_typed <= typed;
        row_want  <= want;
        in_valid  <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // Sender bursts: back-to-back beats, then a random gap.
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // Stops sending and waits until every status beat has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_region_base(input logic [63:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        user_base = value;
    endtask

    // Receiver stall pattern: free stretches, short and long stalls.
    always @(posedge clk)
    begin : sink_pacing
        int pick;
        if (stall_left == 0)
        begin
            pick = $urandom_range(0, 5);
            case (pick)
                0:       begin out_stall <= 1'b0; stall_left = $urandom_range(20, 120); end
                1, 2:    begin out_stall <= 1'b1; stall_left = $urandom_range(1, 6);    end
                3:       begin out_stall <= 1'b1; stall_left = $urandom_range(10, 30);  end
                default: begin out_stall <= 1'b0; stall_left = $urandom_range(1, 8);    end
            endcase
        end
        else
            stall_left--;
    end

    // Predicts on every accepted request beat and checks every status beat.
    always @(posedge clk)
    begin : status_check
        status_exp_t oldest;
        status_exp_t fresh;
        logic        predicted;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
                report_mismatch($sformatf("status beat %0b with no request waiting", status));
            else
            begin
                oldest = pending_status.pop_front();
                if (status !== oldest.status)
                    report_mismatch($sformatf("request %0d: status %0b, expected %0b",
                                              oldest.seq, status, oldest.status));
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            predicted    = run_page_request(action_t'(action), address, byte_size, prot_mask);
            fresh.status = row_typed ? row_want : predicted;
            fresh.seq    = accepted_items;
            pending_status.push_back(fresh);
            accepted_items++;
        end
    end

    // Run limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d status beats outstanding",
                 cycle_count, pending_status.size());
        $display("page_protection_map_core_tb failed");
        $finish;
    end

    initial
    begin
        action_t     act;
        logic [63:0] addr;
        logic [63:0] base;
        logic [31:0] size;
        logic [2:0]  mask;
        logic [63:0] last_addr;
        logic [31:0] last_size;
        logic        have_last;
        int          pick;
        int          r;
        int          ph;
        int          n;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_CHECK;
        address   = '0;
        byte_size = '0;
        prot_mask = '0;
        row_typed = PREDICT;
        row_want  = ST_OK;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        user_base = '0;
        have_last = 1'b0;
        last_addr = '0;
        last_size = '0;
        foreach (page_prot[i])
            page_prot[i] = ENTRY_FREE;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (DIRECTED[r].is_cfg == ROW_CFG)
            begin
                drain();
                write_region_base(DIRECTED[r].addr);
            end
            else
            begin
                send_item(DIRECTED[r].act, DIRECTED[r].addr, DIRECTED[r].size,
                          DIRECTED[r].mask, DIRECTED[r].typed, DIRECTED[r].want);
                pace_sender();
            end
        end

        // Random phases, each under its own region base.
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       base = {$urandom, $urandom} & ~(PAGE_BYTES - 64'd1);
                1:       base = 64'hFFFF_FFFF_0000_0000;
                3:       base = '0;
                default: base = {$urandom, $urandom};
            endcase
            drain();
            write_region_base(base);
            have_last = 1'b0;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 999);
                act  = (pick < 2)   ? ACT_LOCK :
                       (pick < 32)  ? ACT_RESERVED :
                       (pick < 520) ? ACT_CHECK : ACT_UPDATE;
                mask = 3'($urandom_range(0, 7));

                // Often revisit the last range so checks see fresh updates.
                if (have_last && $urandom_range(0, 9) < 4)
                begin
                    addr = last_addr;
                    size = last_size;
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 86)
                        addr = base + {32'd0, 16'($urandom_range(0, WINDOW_PAGES - 1)),
                                       ($urandom_range(0, 1) ? 16'($urandom) : 16'd0)};
                    else if (pick < 91)
                        addr = base + REGION_SPAN - 64'($urandom_range(0, 3 * 65536));
                    else if (pick < 95)
                        addr = base - 64'($urandom_range(1, 4 * 65536));
                    else
                        addr = {$urandom, $urandom};

                    have_last = 1'b1;
                    pick = $urandom_range(0, 99);
                    if (pick < 4)
                    begin
                        // Wide lengths mostly overrun the region end; the rest
                        // are made checks so the table walk stays rare.
                        size      = $urandom;
                        have_last = 1'b0;
                        if ($urandom_range(0, 15) != 0)
                            addr = base + REGION_SPAN - 64'($urandom_range(0, 65535));
                        else
                            act = ACT_CHECK;
                    end
                    else if (pick < 70)
                        size = ($urandom_range(0, 8) << PAGE_SHIFT)
                               | ($urandom_range(0, 1) ? $urandom_range(0, 65535) : 0);
                    else if (pick < 90)
                        size = $urandom_range(0, 65535);
                    else
                        size = $urandom_range(0, 256) << PAGE_SHIFT;
                    last_addr = addr;
                    last_size = size;
                end

                send_item(act, addr, size, mask, PREDICT, ST_OK);
                pace_sender();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("page_protection_map_core_tb passed");
        else
            $display("page_protection_map_core_tb failed");
        $finish;
    end

endmodule
